/* src/drc_pkg.sv */
// Shared types and constants for the drift-compensating resampler.
// Depends on nothing; used by every other file of the block.
package drc_pkg;

    // Default build sizes
    localparam int RING_SAMPLES_DEF = 16384;
    localparam int MAX_BLOCKS_DEF   = 16;
    localparam int FRAC_BITS_DEF    = 16;

    // Fixed field widths
    localparam int CMD_W      = 2;
    localparam int SMP_W      = 24;
    localparam int RATIO_W    = 32;
    localparam int SPB_W      = 13;
    localparam int TGT_W      = 4;
    localparam int BLK_W      = 5;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Q2.30 arithmetic constants
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
    localparam logic [23:0] K_SMOOTH    = 24'd10737418;
    localparam logic [29:0] ONE_MINUS_K = 30'd1063004406;
    localparam logic [20:0] SNAP_TOL    = 21'd1073742;
    localparam logic [26:0] AREA_K      = 27'd85899346;
    localparam logic [29:0] HALF_Q30    = 30'h2000_0000;

    // Buffer length limits
    localparam logic [SPB_W-1:0] N_MIN = 13'd16;
    localparam logic [SPB_W-1:0] N_MAX = 13'd4096;

    // Shared divider sizes
    localparam int DIV_W = 36;
    localparam int DVS_W = 13;
    localparam int DCNT_W = $clog2(DIV_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_START   = 2'd1,
        CMD_REQUEST = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERRUN  = 2'd1,
        ST_FULL      = 2'd2,
        ST_POS_RESET = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SPB    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF    = 2'd2;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* src/drc_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on drc_pkg for widths and the request/response structs.
module drc_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  drc_pkg::div_req_t req,
    output drc_pkg::div_rsp_t rsp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [drc_pkg::DCNT_W-1:0]          cnt_reg;
    logic [drc_pkg::DIV_W-1:0]           quo_reg;
    logic [drc_pkg::DVS_W-1:0]           rem_reg;
    logic [drc_pkg::DVS_W-1:0]           dvs_reg;
    logic [drc_pkg::DVS_W:0]             trial;
    logic                                ge;
    logic [drc_pkg::DVS_W-1:0]           rem_new;

    always_comb
    begin
        trial   = {rem_reg, quo_reg[drc_pkg::DIV_W-1]};
        ge      = trial >= {1'b0, dvs_reg};
        rem_new = ge ? drc_pkg::DVS_W'(trial - {1'b0, dvs_reg})
                     : trial[drc_pkg::DVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[drc_pkg::DIV_W-2:0], ge};
                rem_reg <= rem_new;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == drc_pkg::DCNT_W'(drc_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* src/drift_compensating_resampler_top.sv */
// Top level of the drift-compensating resampler: sample ring, sequencer and datapath.
// Depends on drc_pkg and instantiates drc_div.
//
// Mono time-base corrector. Push words (command 0) fill a sample ring that is
// counted in whole buffers of samples_per_buffer samples (held to 16..4096). A
// block-start word (command 1) compares the held buffer count with target_depth,
// forms a signed quadratic correction of the reference ratio and steers the
// transfer rate towards it, snapping to an integer phase when the rates match and
// clamping to reference +/- 0.01. A request word (command 2) returns one linearly
// interpolated sample, advances the read position and retires whole buffers.
// Every input word produces exactly one result word. A request or block start with
// fewer than two held buffers gives status underrun and a zero sample; a push into
// a full ring is dropped. Words are handled one at a time: a push, an underrun or
// a no-op passes through decode and then the result stage, a request through
// decode (two ring reads), a multiply and an update. A block start is paced by the
// shared bit-serial divider: the rounding divide by buffer count, then, unless the
// rate is clamped, one divide by buffer length, and on a snap a second one. The next
// word is accepted while a result waits in the output register. The ring is not
// cleared after reset and needs no clearing pass; reading an entry never written is
// not meaningful. RING_SAMPLES must be a power of two. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
module drift_compensating_resampler_top
#(
    parameter int RING_SAMPLES = drc_pkg::RING_SAMPLES_DEF,
    parameter int MAX_BLOCKS   = drc_pkg::MAX_BLOCKS_DEF,
    parameter int FRAC_BITS    = drc_pkg::FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input words
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [drc_pkg::CMD_W-1:0]     command,
    input  logic signed [drc_pkg::SMP_W-1:0] sample_in,
    input  logic [drc_pkg::RATIO_W-1:0]   measured_ratio,
    // result words
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [drc_pkg::SMP_W-1:0] sample_out,
    output logic                          sample_valid,
    output logic [drc_pkg::ST_W-1:0]      status,
    output logic [drc_pkg::BLK_W-1:0]     buffered_blocks,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [drc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [drc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW    = $clog2(RING_SAMPLES);
    localparam int IP_W  = 14;
    localparam int POS_W = FRAC_BITS + IP_W;
    localparam int IW    = ((AW > IP_W) ? AW : IP_W) + 1;
    localparam int PRD_W = drc_pkg::SMP_W + 2 + FRAC_BITS;
    localparam int HLD_W = 19;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RQ_MUL,
        S_RQ_UPD,
        S_BS_DIVC,
        S_BS_M1,
        S_BS_M2,
        S_BS_M3,
        S_BS_S1,
        S_BS_S2,
        S_BS_S3,
        S_BS_S4,
        S_BS_DIVR,
        S_BS_DIVS,
        S_FINISH
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers; always ready; the user, not the block, sees that they are written only while idle
    // ------------------------------------------------------------------
    logic [drc_pkg::SPB_W-1:0]   spb_reg;
    logic [drc_pkg::TGT_W-1:0]   tgt_reg;
    logic [drc_pkg::RATIO_W-1:0] ref_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg <= 13'd1024;
            tgt_reg <= 4'd8;
            ref_reg <= drc_pkg::ONE_Q30;
        end
        else if (cfg_valid)
        begin
            priority if (cfg_index == drc_pkg::CFG_SPB)
                spb_reg <= cfg_data[drc_pkg::SPB_W-1:0];
            else if (cfg_index == drc_pkg::CFG_TARGET)
                tgt_reg <= cfg_data[drc_pkg::TGT_W-1:0];
            else if (cfg_index == drc_pkg::CFG_REF)
                ref_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                          state_reg;
    drc_pkg::cmd_t                   cmd_reg;
    logic [drc_pkg::SMP_W-1:0]       smp_in_reg;
    logic [drc_pkg::RATIO_W-1:0]     meas_reg;
    drc_pkg::status_t                st_reg;
    logic [drc_pkg::SMP_W-1:0]       res_smp_reg;
    logic                            res_valid_reg;

    logic [AW-1:0]                   wi_reg;
    logic [11:0]                     fill_reg;
    logic [drc_pkg::BLK_W-1:0]       bc_reg;
    logic [AW-1:0]                   base_reg;
    logic [POS_W-1:0]                pos_reg;
    logic [31:0]                     rate_reg;
    logic signed [39:0]              rate_step_reg;

    // block-start datapath
    logic                            dneg_reg;
    logic                            corr_neg_reg;
    logic [drc_pkg::DIV_W-1:0]       corr_mag_reg;
    logic [51:0]                     hi_reg;
    logic [51:0]                     lo_reg;
    logic signed [39:0]              ideal_reg;
    logic [63:0]                     sm_reg;
    logic signed [65:0]              dprod_reg;
    logic                            step_neg_reg;

    // request datapath
    logic signed [PRD_W-1:0]         prod_reg;

    // output register
    logic                            out_valid_reg;
    logic [drc_pkg::SMP_W-1:0]       sample_out_reg;
    logic                            sample_valid_reg;
    drc_pkg::status_t                status_reg;
    logic [drc_pkg::BLK_W-1:0]       blocks_reg;

    // divider
    drc_pkg::div_req_t               div_req_reg;
    drc_pkg::div_rsp_t               div_rsp;

    drc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Sample ring: one write port, two registered read ports
    // ------------------------------------------------------------------
    logic [drc_pkg::SMP_W-1:0] ring_mem [RING_SAMPLES];
    logic [drc_pkg::SMP_W-1:0] rd1_reg;
    logic [drc_pkg::SMP_W-1:0] rd2_reg;
    logic                      wr_en;
    logic                      rd_en;
    logic [AW-1:0]             rd1_addr;
    logic [AW-1:0]             rd2_addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[wi_reg] <= smp_in_reg;
        if (rd_en)
        begin
            rd1_reg <= ring_mem[rd1_addr];
            rd2_reg <= ring_mem[rd2_addr];
        end
    end

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [drc_pkg::SPB_W-1:0] n_len;
    logic [HLD_W-1:0]          held;
    logic                      ring_full;
    logic                      underrun;
    logic [drc_pkg::SPB_W:0]   fill_inc;
    logic                      pos_bad;
    logic [POS_W-1:0]          pos_ck;
    logic [IW-1:0]             rsum1;
    logic [IW-1:0]             rsum2;
    logic [IW-1:0]             bsum;

    // block start
    logic signed [5:0]         d_s;
    logic [4:0]                ad;
    logic [9:0]                sq;
    logic [36:0]               area_mag;
    logic signed [37:0]        corr_s;
    logic [67:0]               full_prod;
    logic [37:0]               ideal_mag;
    logic [33:0]               smooth;
    logic signed [40:0]        diff_s;
    logic                      dp_neg;
    logic [65:0]               dp_mag;
    logic [65:0]               dp_sum;
    logic [drc_pkg::DIV_W-1:0] slope_mag;
    logic signed [39:0]        slope_s;
    logic signed [39:0]        tgt_s;
    logic signed [39:0]        dev_s;
    logic signed [34:0]        lowb_s;
    logic signed [34:0]        highb_s;
    logic signed [34:0]        cur_s;
    logic                      snap_ok;
    logic [30:0]               rest;
    logic [31:0]               lowb_sat;
    logic [31:0]               highb_sat;

    // request
    logic signed [drc_pkg::SMP_W:0] diff_smp;
    logic signed [PRD_W-1:0]   blend;
    logic [drc_pkg::SMP_W-1:0] interp;
    logic [POS_W-1:0]          pos_add;
    logic [POS_W-1:0]          pos_sub;
    logic                      retire;
    logic                      still_bad;
    logic signed [40:0]        rate_sum;
    logic [31:0]               rate_sat;

    always_comb
    begin
        // buffer length held to its legal range
        if (spb_reg < drc_pkg::N_MIN)
            n_len = drc_pkg::N_MIN;
        else if (spb_reg > drc_pkg::N_MAX)
            n_len = drc_pkg::N_MAX;
        else
            n_len = spb_reg;

        held      = HLD_W'(bc_reg) * HLD_W'(n_len) + HLD_W'(fill_reg);
        ring_full = (bc_reg >= drc_pkg::BLK_W'(MAX_BLOCKS))
                    || (held >= HLD_W'(RING_SAMPLES));
        underrun  = bc_reg < drc_pkg::BLK_W'(2);
        fill_inc  = {2'b00, fill_reg} + 14'd1;

        // position sanity check and ring read addresses
        pos_bad  = pos_reg[POS_W-1:FRAC_BITS] >= IP_W'(n_len);
        pos_ck   = pos_bad ? '0 : pos_reg;
        rsum1    = IW'(base_reg) + IW'(pos_ck[POS_W-1:FRAC_BITS]);
        rsum2    = rsum1 + IW'(1);
        rd1_addr = rsum1[AW-1:0];
        rd2_addr = rsum2[AW-1:0];
        bsum     = IW'(base_reg) + IW'(n_len);

        // quadratic depth error
        d_s      = $signed({1'b0, bc_reg}) - $signed({2'b00, tgt_reg});
        ad       = d_s[5] ? 5'(-d_s) : 5'(d_s);
        sq       = 10'(ad) * 10'(ad);
        area_mag = 37'(drc_pkg::AREA_K) * 37'(sq);

        corr_s   = dneg_reg ? $signed(38'(drc_pkg::ONE_Q30))
                              - $signed({2'b00, div_rsp.quotient})
                            : $signed(38'(drc_pkg::ONE_Q30))
                              + $signed({2'b00, div_rsp.quotient});

        full_prod = {hi_reg, 16'h0000} + 68'(lo_reg);
        ideal_mag = full_prod[67:30];

        smooth   = sm_reg[63:30];
        diff_s   = $signed({ideal_reg[39], ideal_reg}) - $signed({7'b0, smooth});

        dp_neg    = dprod_reg[65];
        dp_mag    = dp_neg ? 66'(-dprod_reg) : 66'(dprod_reg);
        dp_sum    = dp_mag + 66'(drc_pkg::HALF_Q30);
        slope_mag = dp_sum[65:30];
        slope_s   = dp_neg ? -$signed({4'b0, slope_mag}) : $signed({4'b0, slope_mag});
        tgt_s     = $signed({8'b0, rate_reg}) + slope_s;
        dev_s     = tgt_s - $signed(40'(drc_pkg::ONE_Q30));
        snap_ok   = (ideal_reg == $signed(40'(drc_pkg::ONE_Q30)))
                    && (dev_s < $signed(40'(drc_pkg::SNAP_TOL)))
                    && (dev_s > -$signed(40'(drc_pkg::SNAP_TOL)));
        lowb_s    = $signed({3'b0, ref_reg}) - $signed(35'(drc_pkg::K_SMOOTH));
        highb_s   = $signed({3'b0, ref_reg}) + $signed(35'(drc_pkg::K_SMOOTH));
        cur_s     = $signed({3'b0, rate_reg});
        lowb_sat  = lowb_s[34] ? 32'h0 : lowb_s[31:0];
        highb_sat = (highb_s[34:32] != 3'b000) ? 32'hFFFF_FFFF : highb_s[31:0];
        rest      = ((31'(1) << FRAC_BITS) - 31'(pos_reg[FRAC_BITS-1:0]))
                    << (30 - FRAC_BITS);

        // interpolation and position advance
        diff_smp  = $signed({rd2_reg[drc_pkg::SMP_W-1], rd2_reg})
                    - $signed({rd1_reg[drc_pkg::SMP_W-1], rd1_reg});
        blend     = (prod_reg + (PRD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        interp    = rd1_reg + blend[drc_pkg::SMP_W-1:0];
        pos_add   = pos_reg + POS_W'(rate_reg >> (30 - FRAC_BITS));
        retire    = pos_add[POS_W-1:FRAC_BITS] >= IP_W'(n_len);
        pos_sub   = pos_add - (POS_W'(n_len) << FRAC_BITS);
        still_bad = pos_sub[POS_W-1:FRAC_BITS] >= IP_W'(n_len);
        rate_sum  = $signed({9'b0, rate_reg}) + $signed({rate_step_reg[39], rate_step_reg});
        if (rate_sum[40])
            rate_sat = 32'h0;
        else if (rate_sum[39:32] != 8'h00)
            rate_sat = 32'hFFFF_FFFF;
        else
            rate_sat = rate_sum[31:0];

        wr_en = (state_reg == S_DECODE) && (cmd_reg == drc_pkg::CMD_PUSH) && !ring_full;
        rd_en = (state_reg == S_DECODE);
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cmd_reg          <= drc_pkg::CMD_NOP;
            smp_in_reg       <= '0;
            meas_reg         <= '0;
            st_reg           <= drc_pkg::ST_OK;
            res_smp_reg      <= '0;
            res_valid_reg    <= 1'b0;
            wi_reg           <= '0;
            fill_reg         <= '0;
            bc_reg           <= '0;
            base_reg         <= '0;
            pos_reg          <= '0;
            rate_reg         <= drc_pkg::ONE_Q30;
            rate_step_reg    <= '0;
            dneg_reg         <= 1'b0;
            corr_neg_reg     <= 1'b0;
            corr_mag_reg     <= '0;
            hi_reg           <= '0;
            lo_reg           <= '0;
            ideal_reg        <= '0;
            sm_reg           <= '0;
            dprod_reg        <= '0;
            step_neg_reg     <= 1'b0;
            prod_reg         <= '0;
            out_valid_reg    <= 1'b0;
            sample_out_reg   <= '0;
            sample_valid_reg <= 1'b0;
            status_reg       <= drc_pkg::ST_OK;
            blocks_reg       <= '0;
            div_req_reg      <= '0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg       <= drc_pkg::cmd_t'(command);
                        smp_in_reg    <= sample_in;
                        meas_reg      <= measured_ratio;
                        st_reg        <= drc_pkg::ST_OK;
                        res_smp_reg   <= '0;
                        res_valid_reg <= 1'b0;
                        state_reg     <= S_DECODE;
                    end
                end

                S_DECODE:
                begin
                    unique case (cmd_reg)
                        drc_pkg::CMD_PUSH:
                        begin
                            if (ring_full)
                                st_reg <= drc_pkg::ST_FULL;
                            else
                            begin
                                wi_reg <= wi_reg + 1'b1;
                                if (fill_inc >= 14'(n_len))
                                begin
                                    fill_reg <= '0;
                                    bc_reg   <= bc_reg + 1'b1;
                                end
                                else
                                    fill_reg <= fill_inc[11:0];
                            end
                            state_reg <= S_FINISH;
                        end
                        drc_pkg::CMD_START:
                        begin
                            if (underrun)
                            begin
                                st_reg    <= drc_pkg::ST_UNDERRUN;
                                state_reg <= S_FINISH;
                            end
                            else
                            begin
                                // round |AREA_K*d*|d|| / count, half away from zero
                                dneg_reg             <= d_s[5];
                                div_req_reg.start    <= 1'b1;
                                div_req_reg.dividend <= drc_pkg::DIV_W'(area_mag)
                                                        + drc_pkg::DIV_W'(bc_reg >> 1);
                                div_req_reg.divisor  <= drc_pkg::DVS_W'(bc_reg);
                                state_reg            <= S_BS_DIVC;
                            end
                        end
                        drc_pkg::CMD_REQUEST:
                        begin
                            if (underrun)
                            begin
                                st_reg    <= drc_pkg::ST_UNDERRUN;
                                state_reg <= S_FINISH;
                            end
                            else
                            begin
                                // ring reads issued this cycle from pos_ck
                                pos_reg   <= pos_ck;
                                st_reg    <= pos_bad ? drc_pkg::ST_POS_RESET : drc_pkg::ST_OK;
                                state_reg <= S_RQ_MUL;
                            end
                        end
                        drc_pkg::CMD_NOP:
                        begin
                            state_reg <= S_FINISH;
                        end
                        default:
                        begin
                            state_reg <= S_FINISH;
                        end
                    endcase
                end

                S_RQ_MUL:
                begin
                    prod_reg  <= diff_smp * $signed({1'b0, pos_reg[FRAC_BITS-1:0]});
                    state_reg <= S_RQ_UPD;
                end

                S_RQ_UPD:
                begin
                    res_smp_reg   <= interp;
                    res_valid_reg <= 1'b1;
                    rate_reg      <= rate_sat;
                    if (retire)
                    begin
                        base_reg <= bsum[AW-1:0];
                        bc_reg   <= bc_reg - 1'b1;
                        if (still_bad)
                        begin
                            pos_reg <= '0;
                            st_reg  <= drc_pkg::ST_POS_RESET;
                        end
                        else
                            pos_reg <= pos_sub;
                    end
                    else
                        pos_reg <= pos_add;
                    state_reg <= S_FINISH;
                end

                S_BS_DIVC:
                begin
                    if (div_rsp.done)
                    begin
                        corr_neg_reg <= corr_s[37];
                        corr_mag_reg <= corr_s[37] ? drc_pkg::DIV_W'(-corr_s)
                                                   : drc_pkg::DIV_W'(corr_s);
                        state_reg    <= S_BS_M1;
                    end
                end

                S_BS_M1:
                begin
                    hi_reg    <= 52'(corr_mag_reg) * 52'(ref_reg[31:16]);
                    state_reg <= S_BS_M2;
                end

                S_BS_M2:
                begin
                    lo_reg    <= 52'(corr_mag_reg) * 52'(ref_reg[15:0]);
                    state_reg <= S_BS_M3;
                end

                S_BS_M3:
                begin
                    ideal_reg <= corr_neg_reg ? -$signed({2'b00, ideal_mag})
                                              : $signed({2'b00, ideal_mag});
                    state_reg <= S_BS_S1;
                end

                S_BS_S1:
                begin
                    sm_reg    <= 64'(rate_reg) * 64'(drc_pkg::ONE_MINUS_K);
                    state_reg <= S_BS_S2;
                end

                S_BS_S2:
                begin
                    sm_reg    <= sm_reg + 64'(meas_reg) * 64'(drc_pkg::K_SMOOTH)
                                 + 64'(drc_pkg::HALF_Q30);
                    state_reg <= S_BS_S3;
                end

                S_BS_S3:
                begin
                    dprod_reg <= diff_s * $signed({1'b0, drc_pkg::K_SMOOTH});
                    state_reg <= S_BS_S4;
                end

                S_BS_S4:
                begin
                    priority if (snap_ok)
                    begin
                        // lock to unity and pull the phase onto a whole sample
                        rate_reg             <= drc_pkg::ONE_Q30;
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= drc_pkg::DIV_W'(rest);
                        div_req_reg.divisor  <= n_len;
                        state_reg            <= S_BS_DIVR;
                    end
                    else if (cur_s < lowb_s)
                    begin
                        rate_reg      <= lowb_sat;
                        rate_step_reg <= '0;
                        state_reg     <= S_FINISH;
                    end
                    else if (cur_s > highb_s)
                    begin
                        rate_reg      <= highb_sat;
                        rate_step_reg <= '0;
                        state_reg     <= S_FINISH;
                    end
                    else
                    begin
                        step_neg_reg         <= dp_neg;
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= slope_mag;
                        div_req_reg.divisor  <= n_len;
                        state_reg            <= S_BS_DIVS;
                    end
                end

                S_BS_DIVR:
                begin
                    if (div_rsp.done)
                    begin
                        step_neg_reg         <= 1'b0;
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= div_rsp.quotient;
                        div_req_reg.divisor  <= n_len;
                        state_reg            <= S_BS_DIVS;
                    end
                end

                S_BS_DIVS:
                begin
                    if (div_rsp.done)
                    begin
                        rate_step_reg <= step_neg_reg ? -$signed({4'b0, div_rsp.quotient})
                                                      : $signed({4'b0, div_rsp.quotient});
                        state_reg     <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg    <= 1'b1;
                        sample_out_reg   <= res_smp_reg;
                        sample_valid_reg <= res_valid_reg;
                        status_reg       <= st_reg;
                        blocks_reg       <= bc_reg;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign sample_out      = sample_out_reg;
    assign sample_valid    = sample_valid_reg;
    assign status          = status_reg;
    assign buffered_blocks = blocks_reg;

endmodule

/* src/drc_checker.sv */
// Port-level checks for the drift-compensating resampler, bound to its top level.
// Depends on drc_pkg and on the ports of drift_compensating_resampler_top.
module drc_checker
#(
    parameter int MAX_BLOCKS = drc_pkg::MAX_BLOCKS_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [drc_pkg::SMP_W-1:0]     sample_out,
    input logic                          sample_valid,
    input logic [drc_pkg::ST_W-1:0]      status,
    input logic [drc_pkg::BLK_W-1:0]     buffered_blocks
);

    // hold a stalled result word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out)
                                    && $stable(status) && $stable(buffered_blocks))
        else $error("result word changed while stalled");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sample_valid |-> sample_out == '0)
        else $error("sample not zero without valid flag");

    a_served: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_valid |-> status == drc_pkg::ST_OK
                                      || status == drc_pkg::ST_POS_RESET)
        else $error("served sample with bad status");

    a_under: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == drc_pkg::ST_UNDERRUN |-> buffered_blocks < drc_pkg::BLK_W'(2))
        else $error("underrun reported with buffers held");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> buffered_blocks <= drc_pkg::BLK_W'(MAX_BLOCKS))
        else $error("buffer count beyond limit");

endmodule

bind drift_compensating_resampler_top drc_checker
#(
    .MAX_BLOCKS (MAX_BLOCKS)
)
u_drc_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sample_out      (sample_out),
    .sample_valid    (sample_valid),
    .status          (status),
    .buffered_blocks (buffered_blocks)
);

/* sim/drift_compensating_resampler_top_test.sv */
// Self-checking testbench for the drift-compensating resampler top level.
// Depends on drc_pkg and drift_compensating_resampler_top; predicts every result word itself.
module drift_compensating_resampler_top_test;
    import drc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = RING_SAMPLES_DEF;
    localparam int MAXB = MAX_BLOCKS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam longint U32_MAX = 64'h0000_0000_FFFF_FFFF;
    // Settling allowance before a register write or the end
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic [SMP_W-1:0] smp;
        logic             valid;
        status_t          st;
        logic [BLK_W-1:0] blocks;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CMD_W-1:0] command = CMD_NOP;
    logic signed [SMP_W-1:0] sample_in = '0;
    logic [RATIO_W-1:0] measured_ratio = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [SMP_W-1:0] sample_out;
    logic sample_valid;
    logic [ST_W-1:0] status;
    logic [BLK_W-1:0] buffered_blocks;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SPB;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    drift_compensating_resampler_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .sample_in(sample_in), .measured_ratio(measured_ratio),
        .out_valid(out_valid), .out_ready(out_ready),
        .sample_out(sample_out), .sample_valid(sample_valid),
        .status(status), .buffered_blocks(buffered_blocks),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------
    // Predicted copy of the block state and its registers
    // ---------------------------------------------------------------
    logic [SMP_W-1:0] ring_copy [RING];
    bit               ring_written [RING];
    int               wr_idx, fill_cnt, held_blocks, read_base;
    logic [63:0]      read_pos;
    logic [31:0]      xfer_rate;
    longint           ramp_step;
    logic [SPB_W-1:0] spb_reg;
    logic [TGT_W-1:0] depth_reg;
    logic [31:0]      ref_reg;

    result_t pending_results[$];

    int mismatches = 0;
    int words_sent = 0;
    int words_checked = 0;
    int starts_sent = 0;
    int pos_resets = 0;
    int drops_seen = 0;
    int underruns_seen = 0;
    bit quiet = 1'b0;      // no random idling on either side while set
    bit hold_pending = 1'b0;
    int hold_len = 0;

    function automatic int block_len();
        if (spb_reg < N_MIN) return 16;
        if (spb_reg > N_MAX) return 4096;
        return int'(spb_reg);
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint m, q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint mul_ratio(longint a, logic [31:0] b);
        logic [95:0] p;
        longint r;
        p = 96'(unsigned'((a < 0) ? -a : a)) * 96'(b);
        r = longint'(p >> 30);
        return (a < 0) ? -r : r;
    endfunction

    function automatic logic [31:0] clamp_u32(longint v);
        if (v < 0) return 32'd0;
        if (v > U32_MAX) return 32'hFFFF_FFFF;
        return v[31:0];
    endfunction

    // Servo update on a block start: quadratic depth correction, smoothing, snap or clamp
    function automatic void steer_rate(logic [31:0] measured);
        longint n, d, ad, corr, ideal, cur, smooth, tgt, dev, lowb, highb, one, k;
        logic [95:0] sm;
        logic [63:0] frac, rest;
        one = longint'(ONE_Q30);
        k = longint'(K_SMOOTH);
        n = block_len();
        d = held_blocks - longint'(depth_reg);
        ad = (d < 0) ? -d : d;
        corr = one + round_div(longint'(AREA_K) * d * ad, held_blocks);
        ideal = mul_ratio(corr, ref_reg);
        cur = longint'(xfer_rate);
        sm = 96'(xfer_rate) * 96'(ONE_MINUS_K) + 96'(measured) * 96'(K_SMOOTH) + 96'(HALF_Q30);
        smooth = longint'(sm >> 30);
        tgt = cur + round_div((ideal - smooth) * k, one);
        dev = tgt - one;
        lowb = longint'(ref_reg) - k;
        highb = longint'(ref_reg) + k;
        if (ideal == one && dev < longint'(SNAP_TOL) && dev > -longint'(SNAP_TOL)) begin
            frac = read_pos & ((64'd1 << FB) - 1);
            rest = ((64'd1 << FB) - frac) << (30 - FB);
            cur = one;
            tgt = one + longint'(rest / n);
        end
        else if (cur < lowb) begin
            cur = longint'(clamp_u32(lowb));
            tgt = cur;
        end
        else if (cur > highb) begin
            cur = longint'(clamp_u32(highb));
            tgt = cur;
        end
        xfer_rate = cur[31:0];
        ramp_step = (tgt - cur) / n;
    endfunction

    // One served request: interpolate, advance, ramp, retire
    function automatic status_t interp_request(output logic [SMP_W-1:0] smp);
        longint n, ip, frac, s1, s2, v;
        status_t st;
        st = ST_OK;
        n = block_len();
        ip = longint'(read_pos >> FB);
        if (ip >= n) begin
            read_pos = 0;
            ip = 0;
            st = ST_POS_RESET;
        end
        frac = longint'(read_pos & ((64'd1 << FB) - 1));
        s1 = longint'(signed'(ring_copy[(read_base + ip) % RING]));
        s2 = longint'(signed'(ring_copy[(read_base + ip + 1) % RING]));
        v = s1 + (((s2 - s1) * frac + (64'sd1 <<< (FB - 1))) >>> FB);
        smp = v[SMP_W-1:0];
        read_pos = read_pos + 64'(xfer_rate >> (30 - FB));
        xfer_rate = clamp_u32(longint'(xfer_rate) + ramp_step);
        if ((read_pos >> FB) >= n) begin
            read_pos = read_pos - (64'(n) << FB);
            read_base = (read_base + int'(n)) % RING;
            held_blocks--;
            if ((read_pos >> FB) >= n) begin
                read_pos = 0;
                st = ST_POS_RESET;
            end
        end
        return st;
    endfunction

    // A request must never touch a ring entry that was never written
    function automatic bit request_safe();
        longint ip;
        if (held_blocks < 2) return 1'b1;
        ip = longint'(read_pos >> FB);
        if (ip >= block_len()) ip = 0;
        return ring_written[(read_base + ip) % RING] && ring_written[(read_base + ip + 1) % RING];
    endfunction

    function automatic void predict_word(cmd_t cmd, logic [SMP_W-1:0] smp, logic [31:0] meas);
        result_t r;
        int n;
        n = block_len();
        r.smp = '0;
        r.valid = 1'b0;
        r.st = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (held_blocks >= MAXB || held_blocks * n + fill_cnt >= RING) begin
                    r.st = ST_FULL;
                end
                else begin
                    ring_copy[wr_idx] = smp;
                    ring_written[wr_idx] = 1'b1;
                    wr_idx = (wr_idx + 1) % RING;
                    fill_cnt++;
                    if (fill_cnt >= n) begin
                        fill_cnt = 0;
                        held_blocks++;
                    end
                end
            end
            CMD_START: begin
                if (held_blocks < 2) r.st = ST_UNDERRUN;
                else steer_rate(meas);
            end
            CMD_REQUEST: begin
                if (held_blocks < 2) r.st = ST_UNDERRUN;
                else begin
                    r.st = interp_request(r.smp);
                    r.valid = 1'b1;
                end
            end
            default: ;
        endcase
        r.blocks = BLK_W'(held_blocks);
        pending_results.push_back(r);
    endfunction

    // ---------------------------------------------------------------
    // Handshake helpers: signals are driven at the rising edge and
    // sampled at the falling edge, so no result hangs on event order
    // ---------------------------------------------------------------
    task automatic send_word(cmd_t cmd, logic [SMP_W-1:0] smp, logic [31:0] meas);
        int gap;
        if (!quiet && $urandom_range(99) < 7) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        sample_in <= smp;
        measured_ratio <= meas;
        // hold the word until the block takes it
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        predict_word(cmd, smp, meas);
        words_sent++;
        if (cmd == CMD_START) starts_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SPB: spb_reg = val[SPB_W-1:0];
            CFG_TARGET: depth_reg = val[TGT_W-1:0];
            CFG_REF: ref_reg = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(logic [31:0] spb, logic [31:0] depth, logic [31:0] ratio);
        wait_idle();
        write_reg(CFG_SPB, spb);
        write_reg(CFG_TARGET, depth);
        write_reg(CFG_REF, ratio);
    endtask

    // Request where it is safe, else fall back to a push of random data
    task automatic send_request();
        if (request_safe()) send_word(CMD_REQUEST, '0, $urandom);
        else send_word(CMD_PUSH, SMP_W'($urandom), $urandom);
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on demand
    // ---------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_pending) begin
                hold_left = hold_len;
                hold_pending = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else out_ready <= quiet || ($urandom_range(99) >= 7);
        end
    end

    // Checker: compare each accepted result word with the oldest prediction
    always @(negedge clk) begin
        result_t e;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
            end
            else begin
                e = pending_results.pop_front();
                words_checked++;
                if (e.st == ST_POS_RESET) pos_resets++;
                if (e.st == ST_FULL) drops_seen++;
                if (e.st == ST_UNDERRUN) underruns_seen++;
                if (sample_out !== e.smp || sample_valid !== e.valid || status !== e.st
                        || buffered_blocks !== e.blocks) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch word %0d: exp smp=%0d v=%0b st=%0d blk=%0d, got smp=%0d v=%0b st=%0d blk=%0d",
                                 words_checked, signed'(e.smp), e.valid, e.st, e.blocks,
                                 sample_out, sample_valid, status, buffered_blocks);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Underrun, no-op, sample extremes, phase snap, far-off measured ratios, position reset
    task automatic test_directed();
        set_config(64, 3, ONE_Q30);
        send_word(CMD_REQUEST, '0, '0);
        send_word(CMD_START, '0, ONE_Q30);
        send_word(CMD_NOP, 24'h7F_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 192; i++)
            send_word(CMD_PUSH, (i % 3 == 0) ? 24'h80_0000 : (i % 3 == 1) ? 24'h7F_FFFF
                      : SMP_W'($urandom), '0);
        send_word(CMD_START, '0, ONE_Q30);          // depth on target, rates match: snap
        for (int i = 0; i < 40; i++) send_request();
        send_word(CMD_START, '0, 32'hFFFF_FFFF);    // far above
        send_word(CMD_START, '0, 32'h0000_0000);    // far below
        for (int i = 0; i < 4; i++) send_request();
        // shrink the buffer under the read position: next request resets it
        set_config(16, 3, ONE_Q30);
        send_request();
        send_request();
    endtask

    task automatic test_random_phase(logic [31:0] spb, logic [31:0] depth, logic [31:0] ratio,
                                     int count);
        int r;
        cmd_t cmd;
        logic [31:0] meas;
        set_config(spb, depth, ratio);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (held_blocks < 2)
                cmd = (r < 85) ? CMD_PUSH : (r < 92) ? CMD_REQUEST : (r < 97) ? CMD_START : CMD_NOP;
            else if (held_blocks >= 12)
                cmd = (r < 15) ? CMD_PUSH : (r < 90) ? CMD_REQUEST : (r < 97) ? CMD_START : CMD_NOP;
            else
                cmd = (r < 46) ? CMD_PUSH : (r < 90) ? CMD_REQUEST : (r < 97) ? CMD_START : CMD_NOP;
            // mostly near the reference, sometimes anywhere
            if ($urandom_range(99) < 70)
                meas = ref_reg + 32'($urandom_range(0, 2 * 10737418)) - 32'd10737418;
            else meas = $urandom;
            if (cmd == CMD_REQUEST) send_request();
            else send_word(cmd, SMP_W'($urandom), meas);
        end
    endtask

    task automatic test_random();
        test_random_phase(16, 2, 32'h2000_0000, 230);
        test_random_phase(0, 14, 32'h8000_0000, 230);
        quiet = 1'b1;
        test_random_phase(37, 8, ONE_Q30, 230);
        quiet = 1'b0;
        test_random_phase(64, 15, 32'h0000_0000, 230);
        test_random_phase(100, 0, 32'hFFFF_FFFF, 230);
        test_random_phase(24, 5, ONE_Q30, 230);
    endtask

    // Hold the output off long enough that the block fills and stalls its input
    task automatic test_output_stall();
        quiet = 1'b1;
        hold_len = 400;
        hold_pending = 1'b1;
        for (int i = 0; i < 60; i++) begin
            if (i % 2 == 0) send_word(CMD_PUSH, SMP_W'($urandom), '0);
            else send_request();
        end
        quiet = 1'b0;
    endtask

    // Largest buffer length: empty down to one block first, then refill
    task automatic test_large_block();
        for (int i = 0; i < 20000 && held_blocks >= 2; i++) send_request();
        set_config(8191, $urandom_range(2, 14), ONE_Q30 + $urandom_range(0, 1000000));
        for (int i = 0; i < 9000 && held_blocks < 2; i++)
            send_word(CMD_PUSH, SMP_W'($urandom), '0);
        for (int i = 0; i < 30; i++) send_request();
        send_word(CMD_START, '0, ref_reg);
        for (int i = 0; i < 20; i++) send_request();
    endtask

    initial begin
        // predictor reset state
        wr_idx = 0; fill_cnt = 0; held_blocks = 0; read_base = 0;
        read_pos = 0; ramp_step = 0;
        spb_reg = 13'd1024; depth_reg = 4'd8; ref_reg = ONE_Q30;
        xfer_rate = ref_reg;
        for (int i = 0; i < RING; i++) begin
            ring_copy[i] = '0;
            ring_written[i] = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        test_output_stall();
        test_large_block();

        wait_idle();
        $display("Covered %0d words (%0d block starts), %0d results checked.",
                 words_sent, starts_sent, words_checked);
        $display("Seen %0d underruns, %0d dropped pushes, %0d position resets; %0d mismatches.",
                 underruns_seen, drops_seen, pos_resets, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    // Give up well beyond the slowest correct run
    initial begin
        #8_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
